// File: hw/rtl/bpr_pkg.sv
// Package: shared constants, codes and helper functions for the pixel unpacker.
`timescale 1ns / 1ps
`default_nettype none

package bpr_pkg;

  localparam int unsigned RawW       = 32;
  localparam int unsigned RgbW       = 24;
  localparam int unsigned ColW       = 3;
  localparam int unsigned PidxW      = 8;
  localparam int unsigned BppW       = 6;
  localparam int unsigned CfgIdxW    = 3;
  localparam int unsigned CfgDataW   = 32;
  localparam int unsigned ShiftW     = 6;
  localparam int unsigned PaletteDepthDef = 256;

  typedef enum logic {
    OP_PAL_WRITE = 1'b0,
    OP_PIXEL     = 1'b1
  } op_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_BPP         = 3'd0,
    REG_USE_PALETTE = 3'd1,
    REG_RED_MASK    = 3'd2,
    REG_GREEN_MASK  = 3'd3,
    REG_BLUE_MASK   = 3'd4
  } cfg_reg_e;

  // supported pixel depths
  localparam logic [BppW-1:0] Bpp1  = 6'd1;
  localparam logic [BppW-1:0] Bpp2  = 6'd2;
  localparam logic [BppW-1:0] Bpp4  = 6'd4;
  localparam logic [BppW-1:0] Bpp8  = 6'd8;
  localparam logic [BppW-1:0] Bpp16 = 6'd16;
  localparam logic [BppW-1:0] Bpp24 = 6'd24;
  localparam logic [BppW-1:0] Bpp32 = 6'd32;

  localparam logic [BppW-1:0]     BppReset   = Bpp24;
  localparam logic [RawW-1:0]     RedReset   = 32'h00ff_0000;
  localparam logic [RawW-1:0]     GreenReset = 32'h0000_ff00;
  localparam logic [RawW-1:0]     BlueReset  = 32'h0000_00ff;
  localparam logic signed [ShiftW-1:0] RedShiftReset   = 6'sd16;
  localparam logic signed [ShiftW-1:0] GreenShiftReset = 6'sd8;
  localparam logic signed [ShiftW-1:0] BlueShiftReset  = 6'sd0;

  // Channel shift: end of the lowest run of ones, less 8. Adding the lowest
  // set bit to the mask carries through that run, so the end is the trailing
  // zero count of the sum.
  function automatic logic signed [ShiftW-1:0] mask_shift(input logic [RawW-1:0] m);
    logic [RawW:0]     lsb;
    logic [RawW:0]     sum;
    logic [ShiftW-1:0] pos;
    lsb = {1'b0, m & (~m + 32'd1)};
    sum = {1'b0, m} + lsb;
    pos = '0;
    for (int i = RawW; i >= 0; i--) begin
      if (sum[i]) begin
        pos = ShiftW'(i);
      end
    end
    return $signed(pos - ShiftW'(8));
  endfunction

  function automatic logic [7:0] channel(input logic [RawW-1:0] val,
                                         input logic [RawW-1:0] m,
                                         input logic signed [ShiftW-1:0] sh);
    logic [RawW-1:0]   x;
    logic [RawW-1:0]   y;
    logic [ShiftW-1:0] neg;
    x   = val & m;
    neg = ShiftW'(-sh);
    if (sh >= 0) begin
      y = x >> sh[4:0];
    end else begin
      y = x << neg[2:0];
    end
    return y[7:0];
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/bpr_in_if.sv
// Interface: input beat channel carrying palette writes and pixels.
`timescale 1ns / 1ps
`default_nettype none

interface bpr_in_if;
  import bpr_pkg::*;

  logic             valid;
  logic             ready;
  logic             op;
  logic [RawW-1:0]  raw_bytes;
  logic [ColW-1:0]  column_low;
  logic [PidxW-1:0] palette_index;
  logic [RawW-1:0]  palette_entry;

  modport source (output valid, op, raw_bytes, column_low, palette_index, palette_entry,
                  input ready);
  modport sink   (input valid, op, raw_bytes, column_low, palette_index, palette_entry,
                  output ready);
endinterface

`default_nettype wire

// File: hw/rtl/bpr_out_if.sv
// Interface: result beat channel carrying RGB888 and the index flag.
`timescale 1ns / 1ps
`default_nettype none

interface bpr_out_if;
  import bpr_pkg::*;

  logic            valid;
  logic            ready;
  logic [RgbW-1:0] rgb;
  logic            index_error;

  modport source (output valid, rgb, index_error, input ready);
  modport sink   (input valid, rgb, index_error, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/bmp_pixel_to_rgb888.sv
// A beat accepted at the input is registered in stage 1, stage 2 and stage 3 in
// turn, and is presented from stage 3 until it is taken.
// Throughput: one beat per cycle while the output is taken; each stage advances when the next is empty
// or moving, so a stall at the output fills bubbles before it backs up.
// Stages: raw value extraction, mask split and range check, palette read.
// Reset clears the stage valid bits and loads the default configuration;
// the palette is not cleared and holds garbage until written.
`timescale 1ns / 1ps
`default_nettype none

module bmp_pixel_to_rgb888 #(
  parameter int unsigned PALETTE_DEPTH = bpr_pkg::PaletteDepthDef
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  bpr_in_if.sink                              pix_in,
  bpr_out_if.source                           rgb_out,
  input  wire logic                           cfg_we_i,
  input  wire logic [bpr_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  wire logic [bpr_pkg::CfgDataW-1:0]   cfg_wdata_i
);
  import bpr_pkg::*;

  localparam int unsigned AddrW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
  localparam logic [RawW-1:0] DepthW = RawW'(PALETTE_DEPTH);

  // configuration
  logic [BppW-1:0]          bpp_q;
  logic                     use_pal_q;
  logic [RawW-1:0]          red_mask_q, green_mask_q, blue_mask_q;
  logic signed [ShiftW-1:0] red_sh_q, green_sh_q, blue_sh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bpp_q        <= BppReset;
      use_pal_q    <= 1'b0;
      red_mask_q   <= RedReset;
      green_mask_q <= GreenReset;
      blue_mask_q  <= BlueReset;
      red_sh_q     <= RedShiftReset;
      green_sh_q   <= GreenShiftReset;
      blue_sh_q    <= BlueShiftReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_BPP:         bpp_q     <= cfg_wdata_i[BppW-1:0];
        REG_USE_PALETTE: use_pal_q <= cfg_wdata_i[0];
        REG_RED_MASK: begin
          red_mask_q <= cfg_wdata_i;
          red_sh_q   <= mask_shift(cfg_wdata_i);
        end
        REG_GREEN_MASK: begin
          green_mask_q <= cfg_wdata_i;
          green_sh_q   <= mask_shift(cfg_wdata_i);
        end
        REG_BLUE_MASK: begin
          blue_mask_q <= cfg_wdata_i;
          blue_sh_q   <= mask_shift(cfg_wdata_i);
        end
        default: ;
      endcase
    end
  end

  // stage control
  logic s1_valid_q, s2_valid_q, s3_valid_q;
  logic adv1, adv2, adv3;

  assign adv3 = !s3_valid_q || rgb_out.ready;
  assign adv2 = !s2_valid_q || adv3;
  assign adv1 = !s1_valid_q || adv2;
  assign pix_in.ready = adv1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else begin
      if (adv1) s1_valid_q <= pix_in.valid;
      if (adv2) s2_valid_q <= s1_valid_q;
      if (adv3) s3_valid_q <= s2_valid_q;
    end
  end

  // stage 1: raw value extraction, sub-byte pixels MSB first
  logic [RawW-1:0]  raw_val;
  logic [7:0]       byte0;
  logic [ColW-1:0]  ncol;
  logic [RawW-1:0]  s1_val_q;
  logic             s1_op_q;
  logic [PidxW-1:0] s1_pidx_q;

  assign byte0 = pix_in.raw_bytes[7:0];
  assign ncol  = ~pix_in.column_low;

  always_comb begin
    unique case (bpp_q)
      Bpp1:          raw_val = RawW'(byte0[ncol]);
      Bpp2:          raw_val = RawW'(2'(byte0 >> {ncol[1:0], 1'b0}));
      Bpp4:          raw_val = RawW'(4'(byte0 >> {ncol[0], 2'b00}));
      Bpp8:          raw_val = RawW'(byte0);
      Bpp16:         raw_val = RawW'(pix_in.raw_bytes[15:0]);
      Bpp24, Bpp32:  raw_val = pix_in.raw_bytes;
      default:       raw_val = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (adv1) begin
      s1_op_q   <= pix_in.op;
      s1_val_q  <= (pix_in.op == OP_PIXEL) ? raw_val : pix_in.palette_entry;
      s1_pidx_q <= pix_in.palette_index;
    end
  end

  // stage 2: mask split and range check; palette address
  logic [RawW-1:0]  pidx_ext;
  logic [RgbW-1:0]  s2_split_q;
  logic             s2_op_q;
  logic             s2_in_range_q;
  logic [AddrW-1:0] s2_addr_q;

  assign pidx_ext = RawW'(s1_pidx_q);

  always_ff @(posedge clk_i) begin
    if (adv2) begin
      s2_op_q    <= s1_op_q;
      s2_split_q <= {channel(s1_val_q, red_mask_q, red_sh_q),
                     channel(s1_val_q, green_mask_q, green_sh_q),
                     channel(s1_val_q, blue_mask_q, blue_sh_q)};
      if (s1_op_q == OP_PIXEL) begin
        s2_in_range_q <= s1_val_q < DepthW;
        s2_addr_q     <= s1_val_q[AddrW-1:0];
      end else begin
        s2_in_range_q <= pidx_ext < DepthW;
        s2_addr_q     <= pidx_ext[AddrW-1:0];
      end
    end
  end

  // stage 3: palette. Writes land here, so a later pixel's read sees them.
  logic [RgbW-1:0] palette_mem [PALETTE_DEPTH];
  logic            mem_we;
  logic [RgbW-1:0] s3_rd_q;
  logic [RgbW-1:0] s3_split_q;
  logic            s3_op_q;
  logic            s3_in_range_q;

  assign mem_we = s2_valid_q && adv3 && (s2_op_q == OP_PAL_WRITE) && s2_in_range_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      palette_mem[s2_addr_q] <= s2_split_q;
    end
    if (adv3) begin
      s3_rd_q       <= palette_mem[s2_addr_q];
      s3_split_q    <= s2_split_q;
      s3_op_q       <= s2_op_q;
      s3_in_range_q <= s2_in_range_q;
    end
  end

  logic pal_lookup;
  assign pal_lookup = (s3_op_q == OP_PIXEL) && use_pal_q;

  assign rgb_out.valid       = s3_valid_q;
  assign rgb_out.index_error = pal_lookup && !s3_in_range_q;
  assign rgb_out.rgb         = pal_lookup ? (s3_in_range_q ? s3_rd_q : '0) : s3_split_q;

  // checks
  a_err_only_palette: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rgb_out.valid && rgb_out.index_error |-> use_pal_q)
    else $error("index flag raised on mask path");

  a_err_black: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rgb_out.valid && rgb_out.index_error |-> rgb_out.rgb == '0)
    else $error("flagged beat carries colour");

  a_write_no_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rgb_out.valid && s3_op_q == OP_PAL_WRITE |-> !rgb_out.index_error)
    else $error("palette write beat flagged");

  a_we_from_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |=> s3_valid_q && s3_op_q == OP_PAL_WRITE)
    else $error("palette written by a non-write beat");

endmodule

`default_nettype wire

// File: tb/bmp_pixel_to_rgb888_test.sv
// Testbench for bmp_pixel_to_rgb888: directed rows, then random phases, checked against fixed or predicted results.
`timescale 1ns / 1ps

module bmp_pixel_to_rgb888_test;
  import bpr_pkg::*;

  localparam int unsigned PalDepth  = PaletteDepthDef;
  localparam int          Lat       = 3;
  localparam int          CycLimit  = 400000;
  localparam int          PhaseCnt  = 12;
  localparam int          PhaseLen  = 130;
  localparam int          HoldAt    = 300;
  localparam int          HoldLen   = 120;

  typedef struct packed {
    op_e              op;
    logic [RawW-1:0]  raw;
    logic [ColW-1:0]  col;
    logic [PidxW-1:0] pidx;
    logic [RawW-1:0]  pent;
  } pix_beat_t;

  typedef struct packed {
    logic [RgbW-1:0] rgb;
    logic            err;
  } rgb_res_t;

  typedef struct packed {
    bit                    is_reg;
    cfg_reg_e              reg_sel;
    logic [CfgDataW-1:0]   wdata;
    pix_beat_t             beat;
    bit                    typed;
    rgb_res_t              want;
  } stim_row_t;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_wdata_i;

  bpr_in_if  pix_if ();
  bpr_out_if rgb_if ();

  bmp_pixel_to_rgb888 uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pix_in      (pix_if),
    .rgb_out     (rgb_if),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // predictor copy of the configuration and the palette
  logic [BppW-1:0] cur_bpp = BppReset;
  bit              cur_pal = 1'b0;
  logic [RawW-1:0] mask_r  = RedReset;
  logic [RawW-1:0] mask_g  = GreenReset;
  logic [RawW-1:0] mask_b  = BlueReset;
  bit [RgbW-1:0]   pal_copy [PalDepth];
  bit              pal_seen [PalDepth];

  rgb_res_t  rgb_expect_q [$];
  stim_row_t dir_tbl [$];
  int        mismatches  = 0;
  int        tx_idle_pct = 6;
  int        rx_idle_pct = 87;
  int        out_beats   = 0;
  int        hold_left   = 0;
  int        cyc         = 0;

  function automatic logic [7:0] chan_val(logic [RawW-1:0] v, logic [RawW-1:0] m);
    int              tz;
    int              run;
    int              sh;
    logic [RawW-1:0] x;
    if (m == '0) return 8'h00;
    tz = 0;
    while (tz < 32 && !m[tz]) tz++;
    run = 0;
    while (tz + run < 32 && m[tz + run]) run++;
    sh = tz + run - 8;
    x  = v & m;
    if (sh >= 0) x = x >> sh;
    else x = x << (-sh);
    return x[7:0];
  endfunction

  function automatic logic [RgbW-1:0] split_px(logic [RawW-1:0] v);
    return {chan_val(v, mask_r), chan_val(v, mask_g), chan_val(v, mask_b)};
  endfunction

  function automatic logic [RawW-1:0] pix_value(logic [BppW-1:0] d, logic [RawW-1:0] raw,
                                               logic [ColW-1:0] col);
    int off;
    int sh;
    case (d)
      Bpp1, Bpp2, Bpp4, Bpp8: begin
        off = (int'(col) * int'(d)) & 7;
        sh  = 8 - int'(d) - off;
        return RawW'(raw[7:0] >> sh) & ((32'd1 << d) - 32'd1);
      end
      Bpp16:        return {16'h0000, raw[15:0]};
      Bpp24, Bpp32: return raw;
      default:      return '0;
    endcase
  endfunction

  function automatic rgb_res_t predict(pix_beat_t b);
    rgb_res_t        r;
    logic [RawW-1:0] v;
    r = '0;
    if (b.op == OP_PAL_WRITE) begin
      r.rgb = split_px(b.pent);
      pal_copy[b.pidx] = r.rgb;
    end else begin
      v = pix_value(cur_bpp, b.raw, b.col);
      if (!cur_pal) begin
        r.rgb = split_px(v);
      end else if (v < PalDepth) begin
        r.rgb = pal_copy[v[PidxW-1:0]];
      end else begin
        r.err = 1'b1;
      end
    end
    return r;
  endfunction

  function automatic logic [RawW-1:0] run_mask();
    int          w;
    int          pos;
    logic [63:0] m;
    w   = $urandom_range(32, 1);
    pos = $urandom_range(32 - w, 0);
    m   = ((64'd1 << w) - 64'd1) << pos;
    return m[RawW-1:0];
  endfunction

  function automatic logic [RawW-1:0] ext_mask();
    case ($urandom_range(5, 0))
      0:       return '0;
      1:       return '1;
      2:       return 32'h8000_0000;
      3:       return 32'h0000_0001;
      4:       return run_mask();
      default: return $urandom;
    endcase
  endfunction

  // Mostly pixels; in palette mode an index that has never been loaded
  // becomes a palette load of that slot instead.
  function automatic pix_beat_t gen_beat();
    pix_beat_t       b;
    logic [RawW-1:0] v;
    b.op   = ($urandom_range(99, 0) < 15) ? OP_PAL_WRITE : OP_PIXEL;
    b.raw  = $urandom;
    b.col  = ColW'($urandom);
    b.pidx = PidxW'($urandom);
    b.pent = $urandom;
    if (b.op == OP_PIXEL && cur_pal) begin
      if ($urandom_range(99, 0) < 80) begin
        if (cur_bpp == Bpp16) b.raw[15:8] = 8'h00;
        else if (cur_bpp == Bpp24 || cur_bpp == Bpp32) b.raw[31:8] = '0;
      end
      v = pix_value(cur_bpp, b.raw, b.col);
      if (v < PalDepth && !pal_seen[v[PidxW-1:0]]) begin
        b.op   = OP_PAL_WRITE;
        b.pidx = v[PidxW-1:0];
      end
    end
    return b;
  endfunction

  function automatic stim_row_t reg_row(cfg_reg_e r, logic [CfgDataW-1:0] d);
    stim_row_t s;
    s         = '0;
    s.is_reg  = 1'b1;
    s.reg_sel = r;
    s.wdata   = d;
    return s;
  endfunction

  function automatic stim_row_t pix_row(op_e op, logic [RawW-1:0] raw, logic [ColW-1:0] col,
                                        logic [PidxW-1:0] pidx, logic [RawW-1:0] pent,
                                        int typed, logic [RgbW-1:0] rgb, int err);
    stim_row_t s;
    s           = '0;
    s.beat.op   = op;
    s.beat.raw  = raw;
    s.beat.col  = col;
    s.beat.pidx = pidx;
    s.beat.pent = pent;
    s.typed     = (typed != 0);
    s.want.rgb  = rgb;
    s.want.err  = (err != 0);
    return s;
  endfunction

  task automatic set_reg(input cfg_reg_e r, input logic [CfgDataW-1:0] d);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= r;
    cfg_wdata_i <= d;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (r)
      REG_BPP:         cur_bpp = d[BppW-1:0];
      REG_USE_PALETTE: cur_pal = d[0];
      REG_RED_MASK:    mask_r  = d;
      REG_GREEN_MASK:  mask_g  = d;
      REG_BLUE_MASK:   mask_b  = d;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  // valid stays high after an accepted beat; the next call either loads the
  // next beat at once or drops valid for a gap
  task automatic drive_beat(input pix_beat_t b, input bit typed, input rgb_res_t want);
    rgb_res_t r;
    if ($urandom_range(99, 0) < tx_idle_pct) begin
      pix_if.valid <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99, 0) < tx_idle_pct) @(posedge clk_i);
    end
    pix_if.valid         <= 1'b1;
    pix_if.op            <= b.op;
    pix_if.raw_bytes     <= b.raw;
    pix_if.column_low    <= b.col;
    pix_if.palette_index <= b.pidx;
    pix_if.palette_entry <= b.pent;
    if (b.op == OP_PAL_WRITE) pal_seen[b.pidx] = 1'b1;
    @(posedge clk_i);
    while (!pix_if.ready) @(posedge clk_i);
    r = predict(b);
    if (typed) r = want;
    rgb_expect_q.push_back(r);
  endtask

  task automatic settle();
    pix_if.valid <= 1'b0;
    while (rgb_expect_q.size() != 0) @(posedge clk_i);
    repeat (Lat + 2) @(posedge clk_i);
  endtask

  task automatic setup_phase(input int p);
    logic [BppW-1:0] bpp;
    bit              pal;
    logic [RawW-1:0] mr;
    logic [RawW-1:0] mg;
    logic [RawW-1:0] mb;
    pal = 1'b0;
    mr  = RedReset;
    mg  = GreenReset;
    mb  = BlueReset;
    case (p)
      0: begin
        bpp = Bpp32; mr = 32'hff00_0000; mg = 32'h00ff_0000; mb = 32'h0000_ff00;
      end
      1: begin bpp = Bpp16; mr = 32'hf800; mg = 32'h07e0; mb = 32'h001f; end
      2: begin bpp = Bpp8; pal = 1'b1; mr = run_mask(); mg = run_mask(); mb = run_mask(); end
      3: begin bpp = Bpp16; mr = 32'h7c00; mg = 32'h03e0; mb = 32'h001f; end
      4: begin bpp = Bpp1; pal = 1'b1; end
      5: begin bpp = Bpp24; mr = run_mask(); mg = run_mask(); mb = run_mask(); end
      6: begin bpp = Bpp4; pal = 1'b1; mr = $urandom; end
      7: begin bpp = Bpp32; mr = $urandom; mg = $urandom; mb = $urandom; end
      8: begin bpp = Bpp2; pal = 1'b1; mg = run_mask(); end
      9: begin
        bpp = ($urandom_range(2, 0) == 0) ? Bpp16 : ($urandom_range(1, 0) ? Bpp24 : Bpp32);
        pal = 1'b1; mb = run_mask();
      end
      10: begin
        bpp = BppW'($urandom_range(63, 0)); pal = ($urandom_range(1, 0) != 0);
        mr = ext_mask(); mg = ext_mask(); mb = ext_mask();
      end
      default: begin bpp = Bpp24; mr = '1; mg = 32'h1; mb = 32'h8000_0000; end
    endcase
    set_reg(REG_BPP, CfgDataW'(bpp));
    set_reg(REG_USE_PALETTE, CfgDataW'(pal));
    set_reg(REG_RED_MASK, mr);
    set_reg(REG_GREEN_MASK, mg);
    set_reg(REG_BLUE_MASK, mb);
  endtask

  // result side: check each beat, then choose ready for the next edge
  initial begin
    rgb_res_t want;
    rgb_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && rgb_if.valid && rgb_if.ready) begin
        if (rgb_expect_q.size() == 0) begin
          $display("%0t: unexpected beat rgb=%h index_error=%b", $time, rgb_if.rgb,
                   rgb_if.index_error);
          mismatches++;
        end else begin
          want = rgb_expect_q.pop_front();
          if (rgb_if.rgb !== want.rgb) begin
            $display("%0t: rgb expected %h actual %h", $time, want.rgb, rgb_if.rgb);
            mismatches++;
          end
          if (rgb_if.index_error !== want.err) begin
            $display("%0t: index_error expected %b actual %b", $time, want.err,
                     rgb_if.index_error);
            mismatches++;
          end
        end
        out_beats++;
        if (out_beats == HoldAt) hold_left = HoldLen;
      end
      if (hold_left > 0) begin
        hold_left--;
        rgb_if.ready <= 1'b0;
      end else begin
        rgb_if.ready <= ($urandom_range(99, 0) >= rx_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    cyc <= cyc + 1;
    if (cyc > CycLimit) begin
      $display("%0t: timed out with %0d beats outstanding", $time, rgb_expect_q.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    pix_beat_t b;
    rst_ni               <= 1'b0;
    cfg_we_i             <= 1'b0;
    cfg_idx_i            <= REG_BPP;
    cfg_wdata_i          <= '0;
    pix_if.valid         <= 1'b0;
    pix_if.op            <= OP_PIXEL;
    pix_if.raw_bytes     <= '0;
    pix_if.column_low    <= '0;
    pix_if.palette_index <= '0;
    pix_if.palette_entry <= '0;

    // reset defaults: 24 bpp, 8/8/8 masks, no palette
    dir_tbl.push_back(pix_row(OP_PIXEL, 32'h1234_5678, 3'd0, 8'd0, 32'h0, 1, 24'h345678, 0));
    dir_tbl.push_back(pix_row(OP_PIXEL, 32'hffff_ffff, 3'd7, 8'd0, 32'h0, 1, 24'hffffff, 0));
    dir_tbl.push_back(pix_row(OP_PIXEL, 32'h0, 3'd0, 8'd0, 32'h0, 1, 24'h000000, 0));
    dir_tbl.push_back(pix_row(OP_PAL_WRITE, 32'h0, 3'd0, 8'd0, 32'haabb_ccdd, 1, 24'hbbccdd, 0));
    dir_tbl.push_back(pix_row(OP_PAL_WRITE, 32'h0, 3'd0, 8'd255, 32'hffff_ffff, 1,
                              24'hffffff, 0));
    dir_tbl.push_back(pix_row(OP_PAL_WRITE, 32'h0, 3'd0, 8'd1, 32'h0001_0203, 1, 24'h010203, 0));
    dir_tbl.push_back(pix_row(OP_PAL_WRITE, 32'h0, 3'd0, 8'd15, 32'h00f0_0f0f, 1,
                              24'hf00f0f, 0));
    dir_tbl.push_back(pix_row(OP_PAL_WRITE, 32'h0, 3'd0, 8'd3, 32'h0033_3333, 1, 24'h333333, 0));
    dir_tbl.push_back(pix_row(OP_PAL_WRITE, 32'h0, 3'd0, 8'd128, 32'h0080_8080, 1,
                              24'h808080, 0));
    // palette lookups at 1, 2, 4 and 8 bpp, MSB first
    dir_tbl.push_back(reg_row(REG_USE_PALETTE, 32'd1));
    dir_tbl.push_back(reg_row(REG_BPP, 32'd1));
    dir_tbl.push_back(pix_row(OP_PIXEL, 32'h0000_0080, 3'd0, 8'd0, 32'h0, 1, 24'h010203, 0));
    dir_tbl.push_back(pix_row(OP_PIXEL, 32'h0000_0001, 3'd7, 8'd0, 32'h0, 1, 24'h010203, 0));
    dir_tbl.push_back(pix_row(OP_PIXEL, 32'hffff_fffe, 3'd7, 8'd0, 32'h0, 1, 24'hbbccdd, 0));
    dir_tbl.push_back(reg_row(REG_BPP, 32'd2));
    dir_tbl.push_back(pix_row(OP_PIXEL, 32'h0000_0003, 3'd3, 8'd0, 32'h0, 1, 24'h333333, 0));
    dir_tbl.push_back(reg_row(REG_BPP, 32'd4));
    dir_tbl.push_back(pix_row(OP_PIXEL, 32'h0000_00f0, 3'd0, 8'd0, 32'h0, 1, 24'hf00f0f, 0));
    dir_tbl.push_back(reg_row(REG_BPP, 32'd8));
    dir_tbl.push_back(pix_row(OP_PIXEL, 32'hffff_ff80, 3'd5, 8'd0, 32'h0, 1, 24'h808080, 0));
    // index out of range at the wide depths
    dir_tbl.push_back(reg_row(REG_BPP, 32'd16));
    dir_tbl.push_back(pix_row(OP_PIXEL, 32'habcd_0100, 3'd0, 8'd0, 32'h0, 1, 24'h000000, 1));
    dir_tbl.push_back(pix_row(OP_PIXEL, 32'hffff_00ff, 3'd0, 8'd0, 32'h0, 1, 24'hffffff, 0));
    dir_tbl.push_back(reg_row(REG_BPP, 32'd32));
    dir_tbl.push_back(pix_row(OP_PIXEL, 32'hffff_ffff, 3'd0, 8'd0, 32'h0, 1, 24'h000000, 1));
    // unsupported depth gives raw value zero
    dir_tbl.push_back(reg_row(REG_BPP, 32'd5));
    dir_tbl.push_back(pix_row(OP_PIXEL, 32'hffff_ffff, 3'd0, 8'd0, 32'h0, 1, 24'hbbccdd, 0));
    // mask path: 5-6-5, then zero, full and top-bit masks
    dir_tbl.push_back(reg_row(REG_USE_PALETTE, 32'd0));
    dir_tbl.push_back(reg_row(REG_BPP, 32'd16));
    dir_tbl.push_back(reg_row(REG_RED_MASK, 32'h0000_f800));
    dir_tbl.push_back(reg_row(REG_GREEN_MASK, 32'h0000_07e0));
    dir_tbl.push_back(reg_row(REG_BLUE_MASK, 32'h0000_001f));
    dir_tbl.push_back(pix_row(OP_PIXEL, 32'h0000_ffff, 3'd0, 8'd0, 32'h0, 0, '0, 0));
    dir_tbl.push_back(pix_row(OP_PIXEL, 32'h5555_f81f, 3'd2, 8'd0, 32'h0, 0, '0, 0));
    dir_tbl.push_back(reg_row(REG_BPP, 32'd32));
    dir_tbl.push_back(reg_row(REG_RED_MASK, 32'h0));
    dir_tbl.push_back(reg_row(REG_GREEN_MASK, 32'hffff_ffff));
    dir_tbl.push_back(reg_row(REG_BLUE_MASK, 32'h8000_0000));
    dir_tbl.push_back(pix_row(OP_PIXEL, 32'hffff_ffff, 3'd0, 8'd0, 32'h0, 0, '0, 0));
    // scattered and single-bit masks
    dir_tbl.push_back(reg_row(REG_RED_MASK, 32'h00f0_f000));
    dir_tbl.push_back(reg_row(REG_GREEN_MASK, 32'h0000_0001));
    dir_tbl.push_back(reg_row(REG_BLUE_MASK, 32'h0000_0006));
    dir_tbl.push_back(pix_row(OP_PIXEL, 32'ha5a5_a5a5, 3'd0, 8'd0, 32'h0, 0, '0, 0));
    dir_tbl.push_back(pix_row(OP_PAL_WRITE, 32'h0, 3'd0, 8'd2, 32'hffff_ffff, 0, '0, 0));
    dir_tbl.push_back(reg_row(REG_BPP, 32'd63));
    dir_tbl.push_back(pix_row(OP_PIXEL, 32'hffff_ffff, 3'd7, 8'd0, 32'h0, 1, 24'h000000, 0));

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tbl[i]) begin
      if (dir_tbl[i].is_reg) begin
        settle();
        set_reg(dir_tbl[i].reg_sel, dir_tbl[i].wdata);
      end else begin
        drive_beat(dir_tbl[i].beat, dir_tbl[i].typed, dir_tbl[i].want);
      end
    end

    for (int p = 0; p < PhaseCnt; p++) begin
      settle();
      case (p / 4)
        0:       begin tx_idle_pct = 6;  rx_idle_pct = 87; end
        1:       begin tx_idle_pct = 87; rx_idle_pct = 6;  end
        default: begin tx_idle_pct = 0;  rx_idle_pct = 0;  end
      endcase
      setup_phase(p);
      repeat (PhaseLen) begin
        b = gen_beat();
        drive_beat(b, 1'b0, '0);
      end
    end

    settle();
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
